/* hdl/olkd_pkg.sv */
package olkd_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int CNT_OUT_W = 5;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 40;

	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_REAR  = 2'd1,
		OP_DELETE    = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic              ins_front;
		logic              ins_rear;
		logic              del;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

/* hdl/ordered_list_with_key_delete.sv */
// An accepted item's result is registered and shown on the master side in
// the next cycle. Throughput: one item per cycle while m_tready holds;
// all cells compare, shift and read in parallel, whatever the list length.
// Reset: arst_n clears the entry count and the output valid; the cell
// contents stay undefined until written and are never read before that.
module ordered_list_with_key_delete
	import olkd_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// opcode[1:0], value[33:2], position[41:34], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status[2:0], read_value[34:3], entry_count[39:35]
	output logic [OUT_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	op_t               opcode;
	logic [DATA_W-1:0] value;
	logic [POS_W-1:0]  position;
	logic              fire;
	logic              full;
	logic              empty;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	status_t           status;
	cell_ctl_t         ctl;
	logic              valid_q;
	logic [OUT_W-1:0]  res_q;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     count_x;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY:0] found;
	logic [DATA_W-1:0] rd [CAPACITY+1];
	logic [CAPACITY-1:0] occupied;
	logic [CAPACITY-1:0] tail;
	logic [CAPACITY-1:0] sel;

	assign opcode   = op_t'(s_tdata[1:0]);
	assign value    = s_tdata[33:2];
	assign position = s_tdata[41:34];

	assign s_tready = !valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_x    = XW'(position);
	assign count_x  = XW'(count_q);

	assign ctl.ins_front = fire && (opcode == OP_INS_FRONT) && !full;
	assign ctl.ins_rear  = fire && (opcode == OP_INS_REAR) && !full;
	assign ctl.del       = fire && (opcode == OP_DELETE);
	assign ctl.value     = value;

	assign found[0] = 1'b0;
	assign rd[0]    = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occupied[i] = (count_q > CW'(i));
		assign tail[i]     = (count_q == CW'(i));
		assign sel[i]      = occupied[i] && (opcode == OP_READ) && (pos_x == XW'(i + 1));

		olkd_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[i]),
			.tail      (tail[i]),
			.sel       (sel[i]),
			.prev_data ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
			.next_data ((i == CAPACITY - 1) ? value
				: cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.found_in  (found[i]),
			.rd_in     (rd[i]),
			.data      (cell_data[i]),
			.found_out (found[i+1]),
			.rd_out    (rd[i+1])
		);
	end

	always_comb begin
		status  = ST_OK;
		count_d = count_q;
		case (opcode)
			OP_INS_FRONT, OP_INS_REAR: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (found[CAPACITY]) begin
					count_d = count_q - CW'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if ((pos_x == '0) || (pos_x > count_x)) begin
					status = ST_BAD_POS;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= {CNT_OUT_W'(count_d), rd[CAPACITY], status};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q;

endmodule

/* hdl/olkd_cell.sv */
module olkd_cell
	import olkd_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic              occupied,
	input  logic              tail,
	input  logic              sel,
	input  logic [DATA_W-1:0] prev_data,
	input  logic [DATA_W-1:0] next_data,
	input  logic              found_in,
	input  logic [DATA_W-1:0] rd_in,
	output logic [DATA_W-1:0] data,
	output logic              found_out,
	output logic [DATA_W-1:0] rd_out
);

	logic [DATA_W-1:0] data_q;

	assign data      = data_q;
	assign found_out = found_in | (occupied && (data_q == ctl.value));
	assign rd_out    = rd_in | (sel ? data_q : '0);

	always_ff @(posedge clk) begin
		if (ctl.ins_front) begin
			data_q <= prev_data;
		end else if (ctl.ins_rear && tail) begin
			data_q <= ctl.value;
		end else if (ctl.del && found_out) begin
			data_q <= next_data;
		end
	end

endmodule
